### src/kfic_pkg.sv
// Shared types, codes and reset values for the keypad focus and intent controller.
package kfic_pkg;

   // Item kinds
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Key codes
   localparam logic [2:0] KEY_HALT  = 3'd0;
   localparam logic [2:0] KEY_LEFT  = 3'd1;
   localparam logic [2:0] KEY_RIGHT = 3'd2;
   localparam logic [2:0] KEY_MENU  = 3'd3;
   localparam logic [2:0] KEY_OK    = 3'd4;
   localparam logic [2:0] KEY_MODE  = 3'd5;
   localparam logic [2:0] KEY_RATE  = 3'd6;
   localparam logic [2:0] KEY_STOPS = 3'd7;

   // Gesture codes
   localparam logic [1:0] GEST_PRESS   = 2'd0;
   localparam logic [1:0] GEST_CLICK   = 2'd1;
   localparam logic [1:0] GEST_HOLD    = 2'd2;
   localparam logic [1:0] GEST_RELEASE = 2'd3;

   // Focus codes
   localparam logic [2:0] FOCUS_JOG   = 3'd0;
   localparam logic [2:0] FOCUS_SPEED = 3'd1;
   localparam logic [2:0] FOCUS_RATE  = 3'd2;
   localparam logic [2:0] FOCUS_MODE  = 3'd3;
   localparam logic [2:0] FOCUS_STOPS = 3'd4;
   localparam logic [2:0] FOCUS_MENU  = 3'd5;

   // Jog direction codes
   localparam logic [1:0] JOG_NONE  = 2'd0;
   localparam logic [1:0] JOG_LEFT  = 2'd1;
   localparam logic [1:0] JOG_RIGHT = 2'd2;

   // Intent codes
   localparam logic [4:0] INTENT_NONE         = 5'd0;
   localparam logic [4:0] INTENT_CANCEL       = 5'd1;
   localparam logic [4:0] INTENT_JOG_STOP     = 5'd2;
   localparam logic [4:0] INTENT_MENU_CLOSE   = 5'd3;
   localparam logic [4:0] INTENT_MENU_ACT     = 5'd4;
   localparam logic [4:0] INTENT_MENU_PREV    = 5'd5;
   localparam logic [4:0] INTENT_MENU_NEXT    = 5'd6;
   localparam logic [4:0] INTENT_ZERO         = 5'd7;
   localparam logic [4:0] INTENT_SPEED_PREV   = 5'd8;
   localparam logic [4:0] INTENT_SPEED_NEXT   = 5'd9;
   localparam logic [4:0] INTENT_PITCH_PREV   = 5'd10;
   localparam logic [4:0] INTENT_PITCH_NEXT   = 5'd11;
   localparam logic [4:0] INTENT_MODE_PREV    = 5'd12;
   localparam logic [4:0] INTENT_MODE_NEXT    = 5'd13;
   localparam logic [4:0] INTENT_SET_LEFT     = 5'd14;
   localparam logic [4:0] INTENT_SET_RIGHT    = 5'd15;
   localparam logic [4:0] INTENT_CLEAR_LEFT   = 5'd16;
   localparam logic [4:0] INTENT_CLEAR_RIGHT  = 5'd17;
   localparam logic [4:0] INTENT_RUN_LEFT     = 5'd18;
   localparam logic [4:0] INTENT_RUN_RIGHT    = 5'd19;
   localparam logic [4:0] INTENT_JOG_LEFT     = 5'd20;
   localparam logic [4:0] INTENT_JOG_RIGHT    = 5'd21;

   // Configuration register indexes
   localparam logic [0:0] CSR_FOCUS_TIMEOUT = 1'd0;
   localparam logic [0:0] CSR_MENU_COUNT    = 1'd1;

   localparam logic [31:0] FOCUS_TIMEOUT_RESET = 32'd5000;
   localparam logic [5:0]  MENU_COUNT_RESET    = 6'd8;

   // Powered-run latch
   typedef enum logic [2:0] {
      RUN_NONE      = 3'b001,
      RUN_COMMANDED = 3'b010,
      RUN_CONFIRMED = 3'b100
   } run_phase_type;

   typedef struct packed {
      logic        op;
      logic [2:0]  key;
      logic [1:0]  gesture;
      logic        motion_active;
      logic        motion_enabled;
      logic        left_stop_set;
      logic        right_stop_set;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [31:0] focus_timeout_ms;
      logic [5:0]  menu_item_count;
   } cfg_type;

endpackage

### src/kfic_req_if.sv
// Input channel interface: key events and time ticks.
interface kfic_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [2:0]  key;
   logic [1:0]  gesture;
   logic        motion_active;
   logic        motion_enabled;
   logic        left_stop_set;
   logic        right_stop_set;
   logic [31:0] now_ms;

   modport source (
      output valid, op, key, gesture, motion_active, motion_enabled,
             left_stop_set, right_stop_set, now_ms,
      input  ready
   );
   modport sink (
      input  valid, op, key, gesture, motion_active, motion_enabled,
             left_stop_set, right_stop_set, now_ms,
      output ready
   );
endinterface

### src/kfic_rsp_if.sv
// Result channel interface: intent code and focus and menu status.
interface kfic_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] intent;
   logic       timed_out;
   logic [2:0] focus_now;
   logic       menu_is_open;
   logic [5:0] menu_position;

   modport source (
      output valid, intent, timed_out, focus_now, menu_is_open, menu_position,
      input  ready
   );
   modport sink (
      input  valid, intent, timed_out, focus_now, menu_is_open, menu_position,
      output ready
   );
endinterface

### src/kfic_csr_if.sv
// Configuration write channel interface.
interface kfic_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

### src/kfic_csr_regs.sv
// Configuration registers: focus timeout and menu item count.
module kfic_csr_regs
   import kfic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kfic_csr_if.sink   csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FOCUS_TIMEOUT: cfg_in.focus_timeout_ms = csr_chan.data;
            CSR_MENU_COUNT:    cfg_in.menu_item_count  = csr_chan.data[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focus_timeout_ms <= FOCUS_TIMEOUT_RESET;
         cfg_ff.menu_item_count  <= MENU_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/kfic_in_stage.sv
// Input register: captures one transaction from the input channel.
module kfic_in_stage
   import kfic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   kfic_req_if.sink     req_chan,
   input  logic         item_taken,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         load;

   // The register may refill in the same cycle that its content moves on.
   assign req_chan.ready = !valid_ff || item_taken;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.op             <= req_chan.op;
         item_ff.key            <= req_chan.key;
         item_ff.gesture        <= req_chan.gesture;
         item_ff.motion_active  <= req_chan.motion_active;
         item_ff.motion_enabled <= req_chan.motion_enabled;
         item_ff.left_stop_set  <= req_chan.left_stop_set;
         item_ff.right_stop_set <= req_chan.right_stop_set;
         item_ff.now_ms         <= req_chan.now_ms;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/kfic_intent_engine.sv
// Controller state, intent decode and result register.
module kfic_intent_engine
   import kfic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_taken,
   kfic_rsp_if.source   rsp_chan
);

   // Controller state
   logic [2:0]    focus_ff, focus_in;
   logic          menu_open_ff, menu_open_in;
   logic [5:0]    menu_idx_ff, menu_idx_in;
   logic [31:0]   last_act_ff, last_act_in;
   run_phase_type run_ff, run_in;
   logic [1:0]    jog_dir_ff, jog_dir_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    intent_ff, intent_in;
   logic          timed_ff, timed_in;

   logic          arrow, left, sset, act_gest, widget, expired;
   logic [31:0]   idle_ms;
   logic [6:0]    idx_next_wide;
   run_phase_type run_mid;

   assign item_taken = item_valid && (!rsp_valid_ff || rsp_chan.ready);

   assign arrow    = (item.key == KEY_LEFT) || (item.key == KEY_RIGHT);
   assign left     = (item.key == KEY_LEFT);
   assign sset     = left ? item.left_stop_set : item.right_stop_set;
   assign act_gest = (item.gesture == GEST_CLICK) || (item.gesture == GEST_HOLD);
   assign widget   = (focus_ff >= FOCUS_SPEED) && (focus_ff <= FOCUS_STOPS);
   assign idle_ms  = item.now_ms - last_act_ff;
   assign expired  = idle_ms >= cfg.focus_timeout_ms;
   assign idx_next_wide = {1'b0, menu_idx_ff} + 7'd1;

   // Latch reconciled against the machine's motion report.
   always_comb begin
      run_mid = run_ff;
      if (item.motion_active) begin
         if (run_ff == RUN_COMMANDED) begin
            run_mid = RUN_CONFIRMED;
         end
      end else if (run_ff == RUN_CONFIRMED) begin
         run_mid = RUN_NONE;
      end
   end

   always_comb begin
      focus_in     = focus_ff;
      menu_open_in = menu_open_ff;
      menu_idx_in  = menu_idx_ff;
      last_act_in  = last_act_ff;
      run_in       = run_ff;
      jog_dir_in   = jog_dir_ff;
      intent_in    = INTENT_NONE;
      timed_in     = 1'b0;

      if (item.op == OP_TICK) begin
         if (widget && expired) begin
            focus_in = FOCUS_JOG;
            timed_in = 1'b1;
         end
      end else begin
         last_act_in = item.now_ms;
         priority if (item.key == KEY_HALT) begin
            if (item.gesture != GEST_RELEASE) begin
               menu_open_in = 1'b0;
               focus_in     = FOCUS_JOG;
               run_in       = RUN_NONE;
               jog_dir_in   = JOG_NONE;
               intent_in    = INTENT_CANCEL;
            end
         end else if (arrow && item.gesture == GEST_RELEASE && jog_dir_ff != JOG_NONE) begin
            // Dead-man release of a running jog.
            jog_dir_in = JOG_NONE;
            intent_in  = INTENT_JOG_STOP;
         end else begin
            run_in = run_mid;
            priority if (item.key == KEY_MENU) begin
               if (item.gesture == GEST_CLICK) begin
                  if (menu_open_ff) begin
                     menu_open_in = 1'b0;
                     focus_in     = FOCUS_JOG;
                     intent_in    = INTENT_MENU_CLOSE;
                  end else begin
                     menu_open_in = 1'b1;
                     focus_in     = FOCUS_MENU;
                     menu_idx_in  = 6'd0;
                  end
               end
            end else if (menu_open_ff) begin
               if (item.gesture == GEST_CLICK) begin
                  priority if (item.key == KEY_OK) begin
                     intent_in = INTENT_MENU_ACT;
                  end else if (item.key == KEY_LEFT) begin
                     if (menu_idx_ff != 6'd0) begin
                        menu_idx_in = menu_idx_ff - 6'd1;
                        intent_in   = INTENT_MENU_PREV;
                     end
                  end else if (item.key == KEY_RIGHT) begin
                     if (idx_next_wide < {1'b0, cfg.menu_item_count}) begin
                        menu_idx_in = idx_next_wide[5:0];
                        intent_in   = INTENT_MENU_NEXT;
                     end
                  end else begin
                     intent_in = INTENT_NONE;
                  end
               end
            end else if (item.key == KEY_MODE || item.key == KEY_RATE ||
                         item.key == KEY_STOPS) begin
               if (item.gesture == GEST_CLICK) begin
                  priority if (item.key == KEY_MODE) begin
                     focus_in = FOCUS_MODE;
                  end else if (item.key == KEY_RATE) begin
                     focus_in = FOCUS_RATE;
                  end else begin
                     focus_in = FOCUS_STOPS;
                  end
               end
            end else if (item.key == KEY_OK) begin
               if (item.gesture == GEST_CLICK) begin
                  focus_in = widget ? FOCUS_JOG : FOCUS_SPEED;
               end else if (item.gesture == GEST_HOLD && focus_ff == FOCUS_JOG) begin
                  intent_in = INTENT_ZERO;
               end
            end else if (arrow) begin
               unique case (focus_ff)
                  FOCUS_SPEED: begin
                     if (item.gesture == GEST_CLICK) begin
                        intent_in = left ? INTENT_SPEED_PREV : INTENT_SPEED_NEXT;
                     end
                  end
                  FOCUS_RATE: begin
                     if (item.gesture == GEST_CLICK) begin
                        intent_in = left ? INTENT_PITCH_PREV : INTENT_PITCH_NEXT;
                     end
                  end
                  FOCUS_MODE: begin
                     if (item.gesture == GEST_CLICK) begin
                        intent_in = left ? INTENT_MODE_PREV : INTENT_MODE_NEXT;
                     end
                  end
                  FOCUS_STOPS: begin
                     if (!item.motion_enabled && !item.motion_active) begin
                        if (item.gesture == GEST_CLICK && !sset) begin
                           intent_in = left ? INTENT_SET_LEFT : INTENT_SET_RIGHT;
                        end else if (item.gesture == GEST_HOLD && sset) begin
                           intent_in = left ? INTENT_CLEAR_LEFT : INTENT_CLEAR_RIGHT;
                        end
                     end
                  end
                  FOCUS_JOG: begin
                     if (!item.motion_enabled) begin
                        priority if (run_mid != RUN_NONE) begin
                           // An arrow click or hold aborts a powered run.
                           if (act_gest) begin
                              run_in    = RUN_NONE;
                              intent_in = INTENT_CANCEL;
                           end
                        end else if (sset) begin
                           if (act_gest) begin
                              run_in    = RUN_COMMANDED;
                              intent_in = left ? INTENT_RUN_LEFT : INTENT_RUN_RIGHT;
                           end
                        end else if (item.gesture == GEST_PRESS) begin
                           jog_dir_in = left ? JOG_LEFT : JOG_RIGHT;
                           intent_in  = left ? INTENT_JOG_LEFT : INTENT_JOG_RIGHT;
                        end else begin
                           intent_in = INTENT_NONE;
                        end
                     end
                  end
                  default: intent_in = INTENT_NONE;
               endcase
            end else begin
               intent_in = INTENT_NONE;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focus_ff     <= FOCUS_JOG;
         menu_open_ff <= 1'b0;
         menu_idx_ff  <= 6'd0;
         last_act_ff  <= 32'd0;
         run_ff       <= RUN_NONE;
         jog_dir_ff   <= JOG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_taken) begin
            focus_ff     <= focus_in;
            menu_open_ff <= menu_open_in;
            menu_idx_ff  <= menu_idx_in;
            last_act_ff  <= last_act_in;
            run_ff       <= run_in;
            jog_dir_ff   <= jog_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_taken) begin
         intent_ff <= intent_in;
         timed_ff  <= timed_in;
      end
   end

   // Status fields come straight from the state registers, which are only
   // updated together with the result register.
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.intent        = intent_ff;
   assign rsp_chan.timed_out     = timed_ff;
   assign rsp_chan.focus_now     = focus_ff;
   assign rsp_chan.menu_is_open  = menu_open_ff;
   assign rsp_chan.menu_position = menu_idx_ff;

endmodule

### src/keypad_focus_intent_controller_top.sv
// Top level of the keypad focus and intent controller.
//
// The controller turns keypad transactions and periodic time ticks into one
// intent code per transaction, together with the focus, menu open flag and menu
// index that hold after it. Each accepted transaction produces exactly one
// result transaction, in order. Throughput is one transaction per clock cycle
// while results are taken without delay: a transaction first sits in the input
// register, then the intent decode and the single 32-bit idle-time subtract
// and compare settle into the result register together with the controller
// state. The decode reads the state left by the previous transaction
// directly from the state registers, so consecutive transactions need no
// spacing. The input register refills in the same cycle that its content
// moves into the result register. While a finished result waits to be taken,
// the input side can still take one further transaction into the empty input
// register and then stalls until the result is taken. Idle time is worked out
// with wrapping 32-bit arithmetic, so a timer rollover needs no special care.
// Configuration writes are always accepted and should only be issued while
// no transaction is in flight.
module keypad_focus_intent_controller_top
   import kfic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kfic_req_if.sink   req_chan,
   kfic_rsp_if.source rsp_chan,
   kfic_csr_if.sink   csr_chan
);

   cfg_type      cfg;
   logic         item_valid;
   logic         item_taken;
   req_item_type item;

   // Focus timeout and menu item count.
   kfic_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Input register, released when the result register can take the item.
   kfic_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_taken (item_taken),
      .item_valid (item_valid),
      .item       (item)
   );

   // Priority decode, controller state and result register.
   kfic_intent_engine u_intent_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_taken (item_taken),
      .rsp_chan   (rsp_chan)
   );

endmodule
